>>> hdl/i2cts_pkg.sv
// Shared types and constants for the I2C target transaction sequencer.
// Holds the beat structs, command and state codes and clear-mask bits.
// No dependencies; every other file of the block imports this package.
package i2cts_pkg;

    // Default depth of the receive and response stores.
    localparam int STORE_DEPTH_DEF = 64;

    // Reset value of the over-read fill byte register.
    localparam logic [7:0] OVER_READ_FILL_RST = 8'hEE;

    // Host command codes carried in the input beat.
    typedef enum logic [1:0] {
        CMD_POLL      = 2'd0,
        CMD_LOAD      = 2'd1,
        CMD_PROC_DONE = 2'd2,
        CMD_READBACK  = 2'd3
    } cmd_t;

    // Sequencer states as reported in the result beat.
    typedef enum logic [2:0] {
        ST_INIT      = 3'd0,
        ST_WAIT_ADDR = 3'd1,
        ST_WRITE     = 3'd2,
        ST_WAIT_PROC = 3'd3,
        ST_READ      = 3'd4
    } seq_state_t;

    // Flag clear bits.
    localparam logic [4:0] CLR_ADDR     = 5'b00001;
    localparam logic [4:0] CLR_STOP     = 5'b00010;
    localparam logic [4:0] CLR_ARB      = 5'b00100;
    localparam logic [4:0] CLR_TIMEOUT  = 5'b01000;
    localparam logic [4:0] CLR_TXE_NACK = 5'b10000;

    // One input beat.
    typedef struct packed {
        cmd_t       cmd;
        logic       flag_bus_error;
        logic       flag_arb_lost;
        logic       flag_scl_timeout;
        logic       flag_address_match;
        logic       master_writes;
        logic       flag_rx_full;
        logic       flag_stop;
        logic       flag_tx_empty;
        logic [7:0] data_byte;
        logic [5:0] position;
        logic [6:0] response_length;
    } item_t;

    // One result beat.
    typedef struct packed {
        seq_state_t  seq_state;
        logic        tx_write;
        logic [7:0]  tx_value;
        logic [4:0]  clear_mask;
        logic        reinit_port;
        logic [6:0]  received_count;
        logic [6:0]  pending_response;
        logic [31:0] arb_lost_count;
        logic [7:0]  read_data;
    } result_t;

endpackage

>>> hdl/i2c_target_transaction_sequencer_unit.sv
// I2C target transaction sequencer, top level.
// Input and result stages, fill byte register, sequencer and the two byte stores.
// Depends on i2cts_pkg, i2cts_store and i2cts_seq.
//
// Usage: the host sends one beat on s_ per poll of the I2C peripheral flags
// (cmd poll) or per host command (load response byte, command processed,
// read back received byte). Every input beat yields exactly one result beat
// on m_ carrying the sequencer state, the transmit write, the flags to clear,
// the reinit request and the counter views.
// A beat taken on s_ passes the input stage, then the result stage, to m_.
// Throughput is one beat per cycle while m_ready keeps the result stage open;
// each item needs one access to each store, and the store reads are issued as
// the beat enters the input stage.
// The fill byte sent on over-read resets to 0xEE; the user writes it through
// cfg_wr_en/cfg_wr_data only while idle; the block itself does not enforce it.
// Reset puts the sequencer in init with all counters cleared; both stores
// read as zero until written. No clearing pass is needed.
// When m_ready is low the result stage holds its beat, one more beat waits
// in the input stage, and s_ready then drops until the result is taken.
module i2c_target_transaction_sequencer_unit
    import i2cts_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  item_t      s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    m_data,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    localparam int IDX_W  = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic              a_valid_reg;
    item_t             a_item_reg;
    logic              m_valid_reg;
    result_t           m_data_reg;
    logic [7:0]        fill_reg;

    logic              b_open;
    logic              a_advance;
    logic              s_fire;
    result_t           result;
    logic              tx_wr_en, rx_wr_en;
    logic [ADDR_W-1:0] tx_wr_addr, rx_wr_addr, tx_rd_addr, rx_rd_addr;
    logic [7:0]        tx_wr_data, rx_wr_data, tx_rd_data, rx_rd_data;

    // Handshake between the input stage and the result stage.
    assign b_open    = !m_valid_reg || m_ready;
    assign a_advance = a_valid_reg && b_open;
    assign s_ready   = !a_valid_reg || b_open;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Read-back address comes straight from the incoming beat.
    assign rx_rd_addr = ADDR_W'(s_data.position);

    // Input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_item_reg <= s_data;
        end
    end

    // Result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_open) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_advance) begin
            m_data_reg <= result;
        end
    end

    // Over-read fill byte register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= OVER_READ_FILL_RST;
        end else if (cfg_wr_en) begin
            fill_reg <= cfg_wr_data;
        end
    end

    i2cts_seq #(
        .DEPTH  (STORE_DEPTH),
        .IDX_W  (IDX_W),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (a_advance),
        .item           (a_item_reg),
        .over_read_fill (fill_reg),
        .tx_rd_data     (tx_rd_data),
        .rx_rd_data     (rx_rd_data),
        .result         (result),
        .tx_wr_en       (tx_wr_en),
        .tx_wr_addr     (tx_wr_addr),
        .tx_wr_data     (tx_wr_data),
        .tx_rd_addr     (tx_rd_addr),
        .rx_wr_en       (rx_wr_en),
        .rx_wr_addr     (rx_wr_addr),
        .rx_wr_data     (rx_wr_data)
    );

    // Response bytes served to the master.
    i2cts_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_tx_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (tx_wr_data),
        .rd_en   (s_fire),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    // Bytes received from master writes.
    i2cts_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_rx_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (rx_wr_data),
        .rd_en   (s_fire),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    a_advance_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        a_advance |=> m_valid_reg)
        else $error("item left the input stage without a result beat");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid_reg && !m_valid_reg |=> $past(s_valid) == a_valid_reg)
        else $error("empty pipeline did not take an offered beat");

endmodule

>>> hdl/i2cts_store.sv
// Byte store with one write port and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on i2cts_pkg for the default depth.
module i2cts_store
    import i2cts_pkg::*;
#(
    parameter int DEPTH  = STORE_DEPTH_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    localparam int AW1 = ADDR_W + 1;

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_in_range;
    logic             rd_hit;

    assign rd_in_range = ({1'b0, rd_addr} < AW1'(DEPTH));
    assign rd_hit      = wr_en && (wr_addr == rd_addr);
    assign rd_data     = rd_data_reg;

    // Write port; the caller only writes addresses inside the store.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Valid bits stand in for clearing the array at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read; a write to the same address in this cycle is forwarded.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (rd_hit) begin
                rd_data_reg <= wr_data;
            end else if (rd_in_range && valid_reg[rd_addr]) begin
                rd_data_reg <= mem[rd_addr];
            end else begin
                rd_data_reg <= '0;
            end
        end
    end

    a_fwd_same_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en && rd_hit |=> rd_data == $past(wr_data))
        else $error("store read did not forward the concurrent write");

    a_unwritten_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en && !rd_hit && rd_in_range && !valid_reg[rd_addr] |=> rd_data == 8'd0)
        else $error("unwritten store entry did not read as zero");

endmodule

>>> hdl/i2cts_seq.sv
// Sequencer state registers and the single-pass next-state logic.
// Computes the result beat and the store write/read controls for one item.
// Depends on i2cts_pkg for the beat structs, commands and state codes.
module i2cts_seq
    import i2cts_pkg::*;
#(
    parameter int DEPTH  = STORE_DEPTH_DEF,
    parameter int IDX_W  = $clog2(DEPTH + 1),
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  item_t             item,
    input  logic [7:0]        over_read_fill,
    input  logic [7:0]        tx_rd_data,
    input  logic [7:0]        rx_rd_data,
    output result_t           result,
    output logic              tx_wr_en,
    output logic [ADDR_W-1:0] tx_wr_addr,
    output logic [7:0]        tx_wr_data,
    output logic [ADDR_W-1:0] tx_rd_addr,
    output logic              rx_wr_en,
    output logic [ADDR_W-1:0] rx_wr_addr,
    output logic [7:0]        rx_wr_data
);

    localparam int PW = (IDX_W > 6) ? IDX_W : 6;
    localparam int RW = (IDX_W > 7) ? IDX_W : 7;

    seq_state_t       state_reg, state_next, state_eff;
    logic [IDX_W-1:0] rx_index_reg, rx_index_next;
    logic [IDX_W-1:0] tx_index_reg, tx_index_next;
    logic [IDX_W-1:0] rcount_reg, rcount_next;
    logic [IDX_W-1:0] rlen_reg, rlen_next;
    logic             release_reg, release_next;
    logic [31:0]      arb_cnt_reg, arb_cnt_next;

    logic [PW-1:0]    pos_ext;
    logic             pos_ok;
    logic [RW-1:0]    rlen_ext;
    logic [IDX_W-1:0] rlen_sat;
    logic [IDX_W-1:0] tx_index_inc;
    logic             tx_ok;
    logic             rx_we, tx_we;
    logic             tx_write;
    logic [7:0]       tx_value;
    logic [4:0]       clr;
    logic             reinit;
    logic [7:0]       rd;

    // Position and response length range handling.
    assign pos_ext      = PW'(item.position);
    assign pos_ok       = pos_ext < PW'(DEPTH);
    assign rlen_ext     = RW'(item.response_length);
    assign rlen_sat     = (rlen_ext > RW'(DEPTH)) ? IDX_W'(DEPTH) : IDX_W'(rlen_ext);
    assign tx_index_inc = tx_index_reg + 1'b1;
    assign tx_ok        = (tx_index_reg < rlen_reg) && (tx_index_reg < IDX_W'(DEPTH));

    // Next state and result for the item in the input stage.
    always_comb begin
        state_next    = state_reg;
        state_eff     = state_reg;
        rx_index_next = rx_index_reg;
        tx_index_next = tx_index_reg;
        rcount_next   = rcount_reg;
        rlen_next     = rlen_reg;
        release_next  = release_reg;
        arb_cnt_next  = arb_cnt_reg;
        rx_we         = 1'b0;
        tx_we         = 1'b0;
        tx_write      = 1'b0;
        tx_value      = '0;
        clr           = '0;
        reinit        = 1'b0;
        rd            = '0;

        unique case (item.cmd)
            CMD_POLL: begin
                // Bus faults force the port back through init.
                if (item.flag_bus_error || item.flag_arb_lost) begin
                    state_eff = ST_INIT;
                end
                if (item.flag_arb_lost) begin
                    clr          = clr | CLR_ARB;
                    arb_cnt_next = arb_cnt_reg + 32'd1;
                end
                if (item.flag_scl_timeout) begin
                    clr       = clr | CLR_TIMEOUT;
                    state_eff = ST_INIT;
                end
                state_next = state_eff;

                unique case (state_eff)
                    ST_WAIT_ADDR: begin
                        if (item.flag_address_match) begin
                            if (item.master_writes) begin
                                clr           = clr | CLR_ADDR;
                                rx_index_next = '0;
                                rcount_next   = '0;
                                state_next    = ST_WRITE;
                            end else begin
                                tx_index_next = '0;
                                state_next    = ST_WAIT_PROC;
                            end
                        end
                    end
                    ST_WRITE: begin
                        // Bytes past the end of the store are dropped.
                        if (item.flag_rx_full) begin
                            if (rx_index_reg < IDX_W'(DEPTH)) begin
                                rx_we         = 1'b1;
                                rx_index_next = rx_index_reg + 1'b1;
                            end
                        end else if (item.flag_stop) begin
                            clr         = clr | CLR_STOP;
                            rcount_next = rx_index_reg;
                            state_next  = ST_WAIT_ADDR;
                        end else if (item.flag_address_match) begin
                            state_next = ST_WAIT_ADDR;
                        end
                    end
                    ST_WAIT_PROC: begin
                        if (rcount_reg == '0) begin
                            state_next   = ST_READ;
                            release_next = 1'b1;
                        end
                    end
                    ST_READ: begin
                        if (item.flag_tx_empty) begin
                            tx_write = 1'b1;
                            if (tx_ok) begin
                                tx_value      = tx_rd_data;
                                tx_index_next = tx_index_inc;
                                if (tx_index_inc == rlen_reg) begin
                                    rlen_next     = '0;
                                    tx_index_next = '0;
                                end
                            end else begin
                                tx_value = over_read_fill;
                            end
                            if (release_reg) begin
                                release_next = 1'b0;
                                clr          = clr | CLR_ADDR;
                            end
                        end else if (item.flag_address_match) begin
                            clr        = clr | CLR_TXE_NACK;
                            state_next = ST_WAIT_ADDR;
                        end else if (item.flag_stop) begin
                            clr        = clr | CLR_TXE_NACK | CLR_STOP;
                            state_next = ST_WAIT_ADDR;
                        end
                    end
                    default: begin
                        // Init and any unused code reinitialize the port.
                        rx_index_next = '0;
                        rcount_next   = '0;
                        tx_index_next = '0;
                        reinit        = 1'b1;
                        release_next  = 1'b0;
                        state_next    = ST_WAIT_ADDR;
                    end
                endcase
            end
            CMD_LOAD: begin
                tx_we = pos_ok;
            end
            CMD_PROC_DONE: begin
                rcount_next = '0;
                rlen_next   = rlen_sat;
            end
            CMD_READBACK: begin
                if (pos_ok) begin
                    rd = rx_rd_data;
                end
            end
        endcase
    end

    // Result beat shows the state after this item.
    always_comb begin
        result.seq_state        = state_next;
        result.tx_write         = tx_write;
        result.tx_value         = tx_value;
        result.clear_mask       = clr;
        result.reinit_port      = reinit;
        result.received_count   = 7'(rcount_next);
        result.pending_response = 7'(rlen_next);
        result.arb_lost_count   = arb_cnt_next;
        result.read_data        = rd;
    end

    // Store controls; writes land only when the item leaves the input stage.
    assign rx_wr_en   = advance && rx_we;
    assign rx_wr_addr = rx_index_reg[ADDR_W-1:0];
    assign rx_wr_data = item.data_byte;
    assign tx_wr_en   = advance && tx_we;
    assign tx_wr_addr = pos_ext[ADDR_W-1:0];
    assign tx_wr_data = item.data_byte;

    // Prefetch address for the next item: the transmit index it will see.
    assign tx_rd_addr = advance ? tx_index_next[ADDR_W-1:0] : tx_index_reg[ADDR_W-1:0];

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            rx_index_reg <= '0;
            tx_index_reg <= '0;
            rcount_reg   <= '0;
            rlen_reg     <= '0;
            release_reg  <= 1'b0;
            arb_cnt_reg  <= '0;
        end else if (advance) begin
            state_reg    <= state_next;
            rx_index_reg <= rx_index_next;
            tx_index_reg <= tx_index_next;
            rcount_reg   <= rcount_next;
            rlen_reg     <= rlen_next;
            release_reg  <= release_next;
            arb_cnt_reg  <= arb_cnt_next;
        end
    end

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_index_reg <= IDX_W'(DEPTH) && tx_index_reg <= IDX_W'(DEPTH) &&
        rlen_reg <= IDX_W'(DEPTH))
        else $error("sequencer index or length beyond store depth");

    a_arb_count: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.cmd == CMD_POLL && item.flag_arb_lost
        |=> arb_cnt_reg == $past(arb_cnt_reg) + 32'd1)
        else $error("arbitration loss not counted");

endmodule

>>> test/tb_i2c_target_transaction_sequencer_unit.sv
// Self-checking testbench for the I2C target transaction sequencer top level.
// Runs a directed table, then random bus transactions under several idle patterns.
// Depends on i2cts_pkg and i2c_target_transaction_sequencer_unit.
`timescale 1ns / 100ps

module tb_i2c_target_transaction_sequencer_unit
    import i2cts_pkg::*;
();

    localparam int DEPTH = STORE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 312;
    localparam int N_PHASES = 4;

    // One row of the directed table.
    typedef struct {
        item_t   it;
        bit      fixed;
        result_t want;
    } row_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    item_t      s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    result_t    m_data;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    int send_idle = 0;
    int recv_stall = 0;
    int errors = 0;
    int cycle_cnt = 0;

    // Status beats still owed by the block, oldest first.
    result_t status_due_q[$];
    row_t    dir_tab[$];

    // Shadow copy of the sequencer state and the fill byte register.
    seq_state_t  sq_state;
    logic [6:0]  rx_idx;
    logic [6:0]  tx_idx;
    logic [6:0]  rcvd_cnt;
    logic [6:0]  resp_len;
    logic        release_addr;
    logic [31:0] arb_cnt;
    logic [7:0]  rx_mem [DEPTH];
    logic [7:0]  tx_mem [DEPTH];
    logic [7:0]  fill_byte;

    i2c_target_transaction_sequencer_unit #(
        .STORE_DEPTH(DEPTH)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Advance the shadow sequencer by one beat and return the status it produces.
    task automatic sequencer_step(input item_t it, output result_t r);
        logic [4:0] clr;
        clr = '0;
        r = '0;
        case (it.cmd)
            CMD_POLL: begin
                // Bus faults force a reinit before the state is looked at.
                if (it.flag_bus_error || it.flag_arb_lost) sq_state = ST_INIT;
                if (it.flag_arb_lost) begin
                    clr |= CLR_ARB;
                    arb_cnt += 1;
                end
                if (it.flag_scl_timeout) begin
                    clr |= CLR_TIMEOUT;
                    sq_state = ST_INIT;
                end
                case (sq_state)
                    ST_WAIT_ADDR: begin
                        if (it.flag_address_match) begin
                            if (it.master_writes) begin
                                clr |= CLR_ADDR;
                                rx_idx = '0;
                                rcvd_cnt = '0;
                                sq_state = ST_WRITE;
                            end else begin
                                tx_idx = '0;
                                sq_state = ST_WAIT_PROC;
                            end
                        end
                    end
                    ST_WRITE: begin
                        // Bytes past the end of the receive store are dropped.
                        if (it.flag_rx_full) begin
                            if (rx_idx < DEPTH) begin
                                rx_mem[rx_idx[5:0]] = it.data_byte;
                                rx_idx += 1;
                            end
                        end else if (it.flag_stop) begin
                            clr |= CLR_STOP;
                            rcvd_cnt = rx_idx;
                            sq_state = ST_WAIT_ADDR;
                        end else if (it.flag_address_match) begin
                            sq_state = ST_WAIT_ADDR;
                        end
                    end
                    ST_WAIT_PROC: begin
                        if (rcvd_cnt == 0) begin
                            sq_state = ST_READ;
                            release_addr = 1'b1;
                        end
                    end
                    ST_READ: begin
                        // Serve response bytes, then the fill byte on over-read.
                        if (it.flag_tx_empty) begin
                            r.tx_write = 1'b1;
                            if (tx_idx < resp_len && tx_idx < DEPTH) begin
                                r.tx_value = tx_mem[tx_idx[5:0]];
                                tx_idx += 1;
                                if (tx_idx == resp_len) begin
                                    resp_len = '0;
                                    tx_idx = '0;
                                end
                            end else begin
                                r.tx_value = fill_byte;
                            end
                            if (release_addr) begin
                                release_addr = 1'b0;
                                clr |= CLR_ADDR;
                            end
                        end else if (it.flag_address_match) begin
                            clr |= CLR_TXE_NACK;
                            sq_state = ST_WAIT_ADDR;
                        end else if (it.flag_stop) begin
                            clr |= CLR_TXE_NACK | CLR_STOP;
                            sq_state = ST_WAIT_ADDR;
                        end
                    end
                    default: begin
                        rx_idx = '0;
                        rcvd_cnt = '0;
                        tx_idx = '0;
                        r.reinit_port = 1'b1;
                        release_addr = 1'b0;
                        sq_state = ST_WAIT_ADDR;
                    end
                endcase
                r.clear_mask = clr;
            end
            CMD_LOAD: tx_mem[it.position] = it.data_byte;
            CMD_PROC_DONE: begin
                rcvd_cnt = '0;
                resp_len = (it.response_length > DEPTH) ? 7'(DEPTH) : it.response_length;
            end
            default: r.read_data = rx_mem[it.position];
        endcase
        r.seq_state = sq_state;
        r.received_count = rcvd_cnt;
        r.pending_response = resp_len;
        r.arb_lost_count = arb_cnt;
    endtask

    function automatic item_t poll_item(input logic berr, input logic arb, input logic tmo,
                                        input logic addr, input logic mwr, input logic rxf,
                                        input logic stop, input logic txe,
                                        input logic [7:0] data);
        item_t it;
        it = '0;
        it.cmd = CMD_POLL;
        it.flag_bus_error = berr;
        it.flag_arb_lost = arb;
        it.flag_scl_timeout = tmo;
        it.flag_address_match = addr;
        it.master_writes = mwr;
        it.flag_rx_full = rxf;
        it.flag_stop = stop;
        it.flag_tx_empty = txe;
        it.data_byte = data;
        return it;
    endfunction

    function automatic item_t host_item(input cmd_t c, input logic [7:0] data,
                                        input logic [5:0] pos, input logic [6:0] rlen);
        item_t it;
        it = '0;
        it.cmd = c;
        it.data_byte = data;
        it.position = pos;
        it.response_length = rlen;
        return it;
    endfunction

    function automatic result_t status(input seq_state_t st, input logic txw,
                                       input logic [7:0] txv, input logic [4:0] clr,
                                       input logic reinit, input logic [6:0] rc,
                                       input logic [6:0] pend, input logic [31:0] arb,
                                       input logic [7:0] rd);
        result_t r;
        r.seq_state = st;
        r.tx_write = txw;
        r.tx_value = txv;
        r.clear_mask = clr;
        r.reinit_port = reinit;
        r.received_count = rc;
        r.pending_response = pend;
        r.arb_lost_count = arb;
        r.read_data = rd;
        return r;
    endfunction

    // Fully random beat: every field, any command.
    function automatic item_t rand_item();
        logic [31:0] rnd;
        rnd = $urandom;
        return item_t'(rnd[$bits(item_t)-1:0]);
    endfunction

    // Poll with no flags raised and random don't-care fields.
    function automatic item_t quiet_poll();
        item_t it;
        it = rand_item();
        it.cmd = CMD_POLL;
        it.flag_bus_error = 1'b0;
        it.flag_arb_lost = 1'b0;
        it.flag_scl_timeout = 1'b0;
        it.flag_address_match = 1'b0;
        it.master_writes = 1'b0;
        it.flag_rx_full = 1'b0;
        it.flag_stop = 1'b0;
        it.flag_tx_empty = 1'b0;
        return it;
    endfunction

    // Mostly short responses, now and then anything up to the field maximum.
    function automatic logic [6:0] pick_length();
        if ($urandom_range(0, 7) == 0) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, 12));
    endfunction

    // Build one random transaction: mostly well-formed bus traffic, some faults and noise.
    task automatic build_sequence(ref item_t sq[$]);
        int    kind;
        int    n;
        item_t it;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            // Master write: address, data bytes, then stop or a repeated start.
            sq.push_back(poll_item(0, 0, 0, 1, 1, 0, 0, 0, 8'($urandom)));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
            repeat (n) begin
                it = quiet_poll();
                it.master_writes = 1'($urandom_range(0, 1));
                it.flag_tx_empty = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 5) != 0) begin
                    it.flag_rx_full = 1'b1;
                    it.flag_stop = 1'($urandom_range(0, 1));
                    it.flag_address_match = 1'($urandom_range(0, 1));
                end
                sq.push_back(it);
            end
            it = quiet_poll();
            if ($urandom_range(0, 6) == 0) it.flag_address_match = 1'b1;
            else it.flag_stop = 1'b1;
            sq.push_back(it);
        end else if (kind < 50) begin
            // Host side: read back received bytes, load a response, mark processed.
            repeat ($urandom_range(0, 3))
                sq.push_back(host_item(CMD_READBACK, 8'($urandom), 6'($urandom), 7'($urandom)));
            repeat ($urandom_range(0, 5))
                sq.push_back(host_item(CMD_LOAD, 8'($urandom), 6'($urandom), 7'($urandom)));
            sq.push_back(host_item(CMD_PROC_DONE, 8'($urandom), 6'($urandom), pick_length()));
        end else if (kind < 80) begin
            // Master read: usually preceded by the host releasing the response.
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(0, 4))
                    sq.push_back(host_item(CMD_LOAD, 8'($urandom), 6'($urandom), 7'($urandom)));
                sq.push_back(host_item(CMD_PROC_DONE, 8'($urandom), 6'($urandom),
                                       pick_length()));
            end
            sq.push_back(poll_item(0, 0, 0, 1, 0, 0, 0, 0, 8'($urandom)));
            repeat ($urandom_range(1, 2)) begin
                it = quiet_poll();
                it.flag_tx_empty = 1'($urandom_range(0, 1));
                sq.push_back(it);
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 14);
            repeat (n) begin
                it = quiet_poll();
                if ($urandom_range(0, 5) != 0) begin
                    it.flag_tx_empty = 1'b1;
                    it.flag_address_match = 1'($urandom_range(0, 1));
                    it.flag_stop = 1'($urandom_range(0, 1));
                end
                sq.push_back(it);
            end
            it = quiet_poll();
            if ($urandom_range(0, 1) == 0) it.flag_address_match = 1'b1;
            else it.flag_stop = 1'b1;
            sq.push_back(it);
        end else if (kind < 90) begin
            // Bus fault with arbitrary other flags.
            it = quiet_poll();
            {it.flag_bus_error, it.flag_arb_lost, it.flag_scl_timeout} =
                3'($urandom_range(1, 7));
            it.flag_address_match = 1'($urandom_range(0, 1));
            it.master_writes = 1'($urandom_range(0, 1));
            it.flag_rx_full = 1'($urandom_range(0, 1));
            it.flag_stop = 1'($urandom_range(0, 1));
            it.flag_tx_empty = 1'($urandom_range(0, 1));
            sq.push_back(it);
        end else begin
            repeat ($urandom_range(1, 3)) sq.push_back(rand_item());
        end
    endtask

    // Present one beat, wait for it to be taken, and record the status it owes.
    task automatic drive_item(input item_t it, input bit fixed, input result_t want);
        result_t r;
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sequencer_step(it, r);
        status_due_q.push_back(fixed ? want : r);
    endtask

    task automatic compare_status(input result_t got, input result_t want);
        if (got.seq_state !== want.seq_state) begin
            $error("seq_state: expected %0d, actual %0d", want.seq_state, got.seq_state);
            errors++;
        end
        if (got.tx_write !== want.tx_write) begin
            $error("tx_write: expected %0d, actual %0d", want.tx_write, got.tx_write);
            errors++;
        end
        if (got.tx_value !== want.tx_value) begin
            $error("tx_value: expected 0x%02h, actual 0x%02h", want.tx_value, got.tx_value);
            errors++;
        end
        if (got.clear_mask !== want.clear_mask) begin
            $error("clear_mask: expected 0x%02h, actual 0x%02h",
                   want.clear_mask, got.clear_mask);
            errors++;
        end
        if (got.reinit_port !== want.reinit_port) begin
            $error("reinit_port: expected %0d, actual %0d", want.reinit_port, got.reinit_port);
            errors++;
        end
        if (got.received_count !== want.received_count) begin
            $error("received_count: expected %0d, actual %0d",
                   want.received_count, got.received_count);
            errors++;
        end
        if (got.pending_response !== want.pending_response) begin
            $error("pending_response: expected %0d, actual %0d",
                   want.pending_response, got.pending_response);
            errors++;
        end
        if (got.arb_lost_count !== want.arb_lost_count) begin
            $error("arb_lost_count: expected %0d, actual %0d",
                   want.arb_lost_count, got.arb_lost_count);
            errors++;
        end
        if (got.read_data !== want.read_data) begin
            $error("read_data: expected 0x%02h, actual 0x%02h", want.read_data, got.read_data);
            errors++;
        end
    endtask

    // Result side: random back-pressure and a check of every accepted beat.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (status_due_q.size() == 0) begin
                    $error("status beat with nothing outstanding: %p", m_data);
                    errors++;
                end else begin
                    want = status_due_q.pop_front();
                    compare_status(m_data, want);
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        item_t      seq[$];
        int         sent;
        logic [7:0] fill_val;
        int         idle_tab[N_PHASES];
        int         stall_tab[N_PHASES];

        idle_tab = '{0, 80, 0, 32};
        stall_tab = '{0, 0, 80, 32};

        // Shadow state after reset.
        sq_state = ST_INIT;
        rx_idx = '0;
        tx_idx = '0;
        rcvd_cnt = '0;
        resp_len = '0;
        release_addr = 1'b0;
        arb_cnt = '0;
        fill_byte = OVER_READ_FILL_RST;
        foreach (rx_mem[i]) begin
            rx_mem[i] = '0;
            tx_mem[i] = '0;
        end

        // Directed table: a write, read-back, a read with over-read, faults and nacks.
        dir_tab.push_back('{host_item(CMD_READBACK, 8'h00, 6'd0, 7'd0), 1'b1,
                            status(ST_INIT, 0, 8'h00, 5'd0, 0, 7'd0, 7'd0, 0, 8'h00)});
        dir_tab.push_back('{poll_item(0, 0, 0, 0, 0, 0, 0, 0, 8'h00), 1'b1,
                            status(ST_WAIT_ADDR, 0, 8'h00, 5'd0, 1, 7'd0, 7'd0, 0, 8'h00)});
        dir_tab.push_back('{poll_item(0, 0, 0, 1, 1, 0, 0, 0, 8'h00), 1'b1,
                            status(ST_WRITE, 0, 8'h00, CLR_ADDR, 0, 7'd0, 7'd0, 0, 8'h00)});
        dir_tab.push_back('{poll_item(0, 0, 0, 0, 0, 1, 0, 0, 8'hFF), 1'b1,
                            status(ST_WRITE, 0, 8'h00, 5'd0, 0, 7'd0, 7'd0, 0, 8'h00)});
        dir_tab.push_back('{poll_item(0, 0, 0, 0, 0, 1, 0, 0, 8'h00), 1'b1,
                            status(ST_WRITE, 0, 8'h00, 5'd0, 0, 7'd0, 7'd0, 0, 8'h00)});
        dir_tab.push_back('{poll_item(0, 0, 0, 0, 0, 0, 1, 0, 8'h00), 1'b1,
                            status(ST_WAIT_ADDR, 0, 8'h00, CLR_STOP, 0, 7'd2, 7'd0, 0, 8'h00)});
        dir_tab.push_back('{host_item(CMD_READBACK, 8'h00, 6'd0, 7'd0), 1'b1,
                            status(ST_WAIT_ADDR, 0, 8'h00, 5'd0, 0, 7'd2, 7'd0, 0, 8'hFF)});
        dir_tab.push_back('{host_item(CMD_READBACK, 8'h00, 6'd63, 7'd0), 1'b1,
                            status(ST_WAIT_ADDR, 0, 8'h00, 5'd0, 0, 7'd2, 7'd0, 0, 8'h00)});
        dir_tab.push_back('{host_item(CMD_LOAD, 8'hA5, 6'd0, 7'd0), 1'b0, '0});
        dir_tab.push_back('{host_item(CMD_LOAD, 8'h5A, 6'd63, 7'd0), 1'b0, '0});
        dir_tab.push_back('{host_item(CMD_PROC_DONE, 8'h00, 6'd0, 7'd127), 1'b1,
                            status(ST_WAIT_ADDR, 0, 8'h00, 5'd0, 0, 7'd0, 7'd64, 0, 8'h00)});
        dir_tab.push_back('{poll_item(0, 0, 0, 1, 0, 0, 0, 0, 8'h00), 1'b1,
                            status(ST_WAIT_PROC, 0, 8'h00, 5'd0, 0, 7'd0, 7'd64, 0, 8'h00)});
        dir_tab.push_back('{poll_item(0, 0, 0, 0, 0, 0, 0, 0, 8'h00), 1'b1,
                            status(ST_READ, 0, 8'h00, 5'd0, 0, 7'd0, 7'd64, 0, 8'h00)});
        dir_tab.push_back('{poll_item(0, 0, 0, 0, 0, 0, 0, 1, 8'h00), 1'b0, '0});
        dir_tab.push_back('{host_item(CMD_PROC_DONE, 8'h00, 6'd0, 7'd0), 1'b0, '0});
        dir_tab.push_back('{poll_item(0, 0, 0, 0, 0, 0, 0, 1, 8'h00), 1'b1,
                            status(ST_READ, 1, 8'hEE, 5'd0, 0, 7'd0, 7'd0, 0, 8'h00)});
        dir_tab.push_back('{poll_item(0, 0, 0, 0, 0, 0, 1, 0, 8'h00), 1'b0, '0});
        dir_tab.push_back('{poll_item(0, 1, 0, 0, 0, 0, 0, 0, 8'h00), 1'b1,
                            status(ST_WAIT_ADDR, 0, 8'h00, CLR_ARB, 1, 7'd0, 7'd0, 1, 8'h00)});
        dir_tab.push_back('{poll_item(1, 0, 1, 0, 0, 0, 0, 0, 8'h00), 1'b1,
                            status(ST_WAIT_ADDR, 0, 8'h00, CLR_TIMEOUT, 1, 7'd0, 7'd0, 1,
                                   8'h00)});
        dir_tab.push_back('{poll_item(1, 1, 1, 1, 1, 1, 1, 1, 8'hFF), 1'b0, '0});
        dir_tab.push_back('{poll_item(0, 0, 0, 1, 0, 0, 0, 0, 8'h00), 1'b0, '0});
        dir_tab.push_back('{poll_item(0, 0, 0, 0, 0, 0, 0, 0, 8'h00), 1'b0, '0});
        dir_tab.push_back('{poll_item(0, 0, 0, 1, 0, 0, 0, 0, 8'h00), 1'b0, '0});
        dir_tab.push_back('{poll_item(0, 0, 0, 1, 1, 0, 0, 0, 8'h00), 1'b0, '0});
        dir_tab.push_back('{poll_item(0, 0, 0, 1, 1, 0, 0, 0, 8'h00), 1'b0, '0});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[k]) drive_item(dir_tab[k].it, dir_tab[k].fixed, dir_tab[k].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // Drain completely before touching the fill byte register.
            s_valid <= 1'b0;
            while (status_due_q.size() != 0) @(posedge aclk);
            if (ph == 0) fill_val = 8'h00;
            else if (ph == 1) fill_val = 8'hFF;
            else fill_val = 8'($urandom_range(1, 254));
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= fill_val;
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            fill_byte = fill_val;

            send_idle = idle_tab[ph];
            recv_stall = stall_tab[ph];
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                seq.delete();
                build_sequence(seq);
                foreach (seq[k]) drive_item(seq[k], 1'b0, '0);
                sent += seq.size();
            end
        end

        // Let the last beats come out, then keep watching the result side for strays.
        s_valid <= 1'b0;
        while (status_due_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
